[rtl/core/ghgw_pkg.sv]
package ghgw_pkg;

    // Node indexes are 4 bits wide, so the graph holds exactly 1 << NODE_W nodes.
    localparam int NODE_W     = 4;
    localparam int NODE_COUNT = 1 << NODE_W;
    localparam int EDGE_DEPTH = NODE_COUNT * NODE_COUNT;
    localparam int EDGE_AW    = 2 * NODE_W;
    localparam int WEIGHT_W   = 16;
    localparam int HEUR_W     = 16;
    localparam int PATH_DEPTH = 32;
    localparam int PATH_AW    = $clog2(PATH_DEPTH);
    localparam int LEN_W      = $clog2(PATH_DEPTH + 1);
    localparam int MAX_MOVES  = PATH_DEPTH - 2;
    localparam int COST_W     = 21;
    localparam int STEPS_W    = 5;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [MODE_W-1:0] MODE_EDGE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HEUR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RUN  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_GOAL  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_DEAD  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_LIMIT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS = 2'd2;

    localparam logic [NODE_W-1:0]  START_RST = '0;
    localparam logic [NODE_W-1:0]  GOAL_RST  = '0;
    localparam logic [STEPS_W-1:0] STEPS_RST = 5'd30;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic issue;
        logic proc;
        logic advance;
        logic end_dead;
        logic end_limit;
        logic latch_final;
        logic emit;
    } t_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic run_mode;
        logic goal_hit;
        logic scan_done;
        logic issue_done;
        logic found;
        logic at_limit;
        logic out_free;
        logic emit_last;
    } t_stat;

endpackage

[rtl/core/ghgw_in_if.sv]
interface ghgw_in_if import ghgw_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [NODE_W-1:0]   from_node;
    logic [NODE_W-1:0]   to_node;
    logic [WEIGHT_W-1:0] edge_weight;
    logic [HEUR_W-1:0]   heuristic_value;

    modport source (output valid, mode, from_node, to_node, edge_weight, heuristic_value,
                    input ready);
    modport sink (input valid, mode, from_node, to_node, edge_weight, heuristic_value,
                  output ready);
endinterface

[rtl/core/ghgw_out_if.sv]
interface ghgw_out_if import ghgw_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [NODE_W-1:0]   path_node;
    logic [COST_W-1:0]   path_cost;
    logic [HEUR_W-1:0]   final_heuristic;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, path_node, path_cost, final_heuristic, status, last,
                    input ready);
    modport sink (input valid, path_node, path_cost, final_heuristic, status, last,
                  output ready);
endinterface

[rtl/core/ghgw_ram.sv]
module ghgw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/ghgw_ctrl.sv]
module ghgw_ctrl import ghgw_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_FINAL  = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                // No word is taken while reset is held.
                o_in_ready   = i_rst_n;
                o_cmd.accept = i_in_valid && i_rst_n;
                if (i_in_valid && i_stat.run_mode) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.issue = !i_stat.issue_done;
                o_cmd.proc  = 1'b1;
                if (i_stat.goal_hit) begin
                    n_state = S_FINAL;
                end else if (i_stat.scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!i_stat.found) begin
                    o_cmd.end_dead = 1'b1;
                    n_state        = S_FINAL;
                end else if (i_stat.at_limit) begin
                    o_cmd.end_limit = 1'b1;
                    n_state         = S_FINAL;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_FINAL: begin
                o_cmd.latch_final = 1'b1;
                n_state           = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = i_stat.out_free;
                if (i_stat.out_free && i_stat.emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/ghgw_dp.sv]
module ghgw_dp import ghgw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [NODE_W-1:0]     i_from_node,
    input  logic [NODE_W-1:0]     i_to_node,
    input  logic [WEIGHT_W-1:0]   i_edge_weight,
    input  logic [HEUR_W-1:0]     i_heuristic_value,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [NODE_W-1:0]     o_path_node,
    output logic [COST_W-1:0]     o_path_cost,
    output logic [HEUR_W-1:0]     o_final_heuristic,
    output logic [STATUS_W-1:0]   o_status,
    output logic                  o_last
);

    // Configuration registers.
    logic [NODE_W-1:0]  r_start;
    logic [NODE_W-1:0]  r_goal;
    logic [STEPS_W-1:0] r_steps;

    // Tables: edge weights in RAM with one valid bit per entry, heuristics in flops.
    logic [EDGE_DEPTH-1:0] r_ev;
    logic [HEUR_W-1:0]     r_heur [NODE_COUNT];

    // Walk state.
    logic [NODE_W:0]     r_idx;
    logic                r_pv;
    logic [NODE_W-1:0]   r_pidx;
    logic                r_evq;
    logic                r_found;
    logic [NODE_W-1:0]   r_best;
    logic [WEIGHT_W-1:0] r_best_w;
    logic [HEUR_W-1:0]   r_best_h;
    logic [NODE_W-1:0]   r_cur;
    logic [LEN_W-1:0]    r_len;
    logic [LEN_W-1:0]    r_moves;
    logic [LEN_W-1:0]    r_limit;
    logic [LEN_W-1:0]    r_k;
    logic [COST_W-1:0]   r_cost;
    logic [STATUS_W-1:0] r_status;
    logic [HEUR_W-1:0]   r_final_h;
    logic [NODE_W-1:0]   r_path [PATH_DEPTH];

    // Output word register.
    logic                r_o_valid;
    logic [NODE_W-1:0]   r_o_node;
    logic [COST_W-1:0]   r_o_cost;
    logic [HEUR_W-1:0]   r_o_heur;
    logic [STATUS_W-1:0] r_o_status;
    logic                r_o_last;

    logic                edge_we;
    logic                heur_we;
    logic                run_go;
    logic [EDGE_AW-1:0]  edge_raddr;
    logic [WEIGHT_W-1:0] ram_q;
    logic [WEIGHT_W-1:0] w;
    logic [NODE_W-1:0]   h_addr;
    logic [HEUR_W-1:0]   h_rd;
    logic                has_edge;
    logic                goal_hit;
    logic                better;
    logic                ps_we;
    logic [PATH_AW-1:0]  ps_waddr;
    logic [NODE_W-1:0]   ps_wdata;
    logic [LEN_W-1:0]    steps_ext;
    logic                out_free;
    logic                emit_last;

    assign edge_we    = i_cmd.accept && (i_mode == MODE_EDGE);
    assign heur_we    = i_cmd.accept && (i_mode == MODE_HEUR);
    assign run_go     = i_cmd.accept && (i_mode == MODE_RUN);
    assign edge_raddr = {r_cur, r_idx[NODE_W-1:0]};

    ghgw_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (EDGE_DEPTH)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr ({i_from_node, i_to_node}),
        .i_wdata (i_edge_weight),
        .i_raddr (edge_raddr),
        .o_rdata (ram_q)
    );

    // An entry never written since reset reads as no edge.
    assign w        = r_evq ? ram_q : '0;
    assign h_addr   = i_cmd.latch_final ? r_cur : r_pidx;
    assign h_rd     = r_heur[h_addr];
    assign has_edge = r_pv && (w != '0);
    assign goal_hit = has_edge && (r_pidx == r_goal);
    assign better   = has_edge && !goal_hit && (!r_found || (h_rd < r_best_h));

    assign steps_ext = LEN_W'(r_steps);
    assign out_free  = !r_o_valid || i_out_ready;
    assign emit_last = (r_k + LEN_W'(1)) == r_len;

    always_comb begin
        o_stat            = '0;
        o_stat.run_mode   = (i_mode == MODE_RUN);
        o_stat.goal_hit   = goal_hit;
        o_stat.scan_done  = r_pv && (r_pidx == NODE_W'(NODE_COUNT - 1));
        o_stat.issue_done = r_idx[NODE_W];
        o_stat.found      = r_found;
        o_stat.at_limit   = r_moves >= r_limit;
        o_stat.out_free   = out_free;
        o_stat.emit_last  = emit_last;
    end

    // Path store write port: start node, goal on a hit, or the chosen neighbor.
    always_comb begin
        ps_we    = 1'b0;
        ps_waddr = r_len[PATH_AW-1:0];
        ps_wdata = r_best;
        if (run_go) begin
            ps_we    = 1'b1;
            ps_waddr = '0;
            ps_wdata = r_start;
        end else if (i_cmd.proc && goal_hit) begin
            ps_we    = 1'b1;
            ps_wdata = r_goal;
        end else if (i_cmd.advance) begin
            ps_we    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= START_RST;
            r_goal  <= GOAL_RST;
            r_steps <= STEPS_RST;
            r_ev    <= '0;
            for (int j = 0; j < NODE_COUNT; j++) begin
                r_heur[j] <= '0;
            end
            r_idx     <= '0;
            r_pv      <= 1'b0;
            r_found   <= 1'b0;
            r_len     <= '0;
            r_moves   <= '0;
            r_k       <= '0;
            r_cost    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_START: r_start <= i_cfg_data[NODE_W-1:0];
                    CFG_GOAL:  r_goal  <= i_cfg_data[NODE_W-1:0];
                    CFG_STEPS: r_steps <= i_cfg_data[STEPS_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (edge_we) begin
                r_ev[{i_from_node, i_to_node}] <= 1'b1;
            end
            if (heur_we) begin
                r_heur[i_from_node] <= i_heuristic_value;
            end

            r_pv <= i_cmd.issue;
            if (i_cmd.issue) begin
                r_idx <= r_idx + (NODE_W + 1)'(1);
            end

            if (run_go) begin
                r_idx   <= '0;
                r_found <= 1'b0;
                r_len   <= LEN_W'(1);
                r_moves <= '0;
                r_cost  <= '0;
            end

            if (i_cmd.proc && goal_hit) begin
                r_len  <= r_len + LEN_W'(1);
                r_cost <= r_cost + COST_W'(w);
            end else if (i_cmd.proc && better) begin
                r_found <= 1'b1;
            end

            if (i_cmd.advance) begin
                r_len   <= r_len + LEN_W'(1);
                r_cost  <= r_cost + COST_W'(r_best_w);
                r_moves <= r_moves + LEN_W'(1);
                r_found <= 1'b0;
                r_idx   <= '0;
            end

            if (i_cmd.latch_final) begin
                r_k <= '0;
            end

            if (i_cmd.emit) begin
                r_k       <= r_k + LEN_W'(1);
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= r_idx[NODE_W-1:0];
        r_evq  <= r_ev[edge_raddr];
        if (ps_we) begin
            r_path[ps_waddr] <= ps_wdata;
        end
        if (run_go) begin
            r_cur   <= r_start;
            r_limit <= (steps_ext > LEN_W'(MAX_MOVES)) ? LEN_W'(MAX_MOVES) : steps_ext;
        end
        if (i_cmd.proc && goal_hit) begin
            r_cur    <= r_goal;
            r_status <= STAT_GOAL;
        end else if (i_cmd.proc && better) begin
            r_best   <= r_pidx;
            r_best_w <= w;
            r_best_h <= h_rd;
        end
        if (i_cmd.advance) begin
            r_cur <= r_best;
        end
        if (i_cmd.end_dead) begin
            r_status <= STAT_DEAD;
        end
        if (i_cmd.end_limit) begin
            r_status <= STAT_LIMIT;
        end
        if (i_cmd.latch_final) begin
            r_final_h <= h_rd;
        end
        if (i_cmd.emit) begin
            r_o_node   <= r_path[r_k[PATH_AW-1:0]];
            r_o_cost   <= r_cost;
            r_o_heur   <= r_final_h;
            r_o_status <= r_status;
            r_o_last   <= emit_last;
        end
    end

    assign o_out_valid       = r_o_valid;
    assign o_path_node       = r_o_node;
    assign o_path_cost       = r_o_cost;
    assign o_final_heuristic = r_o_heur;
    assign o_status          = r_o_status;
    assign o_last            = r_o_last;

endmodule

[rtl/core/greedy_heuristic_graph_walk.sv]
// Load words (edge or heuristic writes) are taken one per cycle and give no result.
// A run scans one adjacency row per greedy move: every row entry is read through the
// single edge RAM port, the last registered read is checked, then the move is decided.
// A goal scan ends on the cycle after the goal entry is read; a final state then fetches
// the final heuristic, and one path word leaves per cycle while the sink keeps up; the
// input is held off until the last path word is registered. Synchronous active-low reset
// clears the edge valid bits, heuristics and walk counters and resets the configuration.
module greedy_heuristic_graph_walk import ghgw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ghgw_in_if.sink               i_in,
    ghgw_out_if.source            o_out
);

    // The controller sequences row scans, step decisions and path emission. The
    // datapath holds the edge RAM with its per-entry valid bits (so reset needs no
    // clearing pass), the heuristic registers, the path store and the output word
    // register. During a scan, one row entry is read per cycle; the entry arrives in the
    // following cycle, where the goal check and the least-heuristic compare take place.
    // A goal hit ends the scan at once, so entries after the goal are never looked at.

    t_cmd  cmd;
    t_stat stat;

    ghgw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ghgw_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_mode            (i_in.mode),
        .i_from_node       (i_in.from_node),
        .i_to_node         (i_in.to_node),
        .i_edge_weight     (i_in.edge_weight),
        .i_heuristic_value (i_in.heuristic_value),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_path_node       (o_out.path_node),
        .o_path_cost       (o_out.path_cost),
        .o_final_heuristic (o_out.final_heuristic),
        .o_status          (o_out.status),
        .o_last            (o_out.last)
    );

endmodule
